@@ design/max_time_interval_error_macros.svh @@
// Assertion macros shared by the MTIE checker.
`ifndef MAX_TIME_INTERVAL_ERROR_MACROS_SVH
`define MAX_TIME_INTERVAL_ERROR_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define MTIE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define MTIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mtie_pkg.sv @@
// Shared types and constants for the MTIE block.
`default_nettype none

package mtie_pkg;

    localparam int SAMPLE_BITS = 32;  // input phase field width
    localparam int SWING_BITS  = 32;  // result swing width
    localparam int WLEN_BITS   = 8;   // window_len register width

    // controller -> datapath
    typedef struct packed {
        logic load;    // item accepted: write ring, start series step
        logic read;    // issue one ring read, step pointer and count
        logic swing;   // fold window swing into the worst swing
        logic finish;  // last item: load result register, clear series
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_window;   // series holds at least m+1 samples
        logic scan_empty;  // no ring reads left
        logic scan_last;   // one ring read left
        logic is_last;     // current item closes the series
        logic out_free;    // result register can take a new item
    } t_status;

endpackage

`default_nettype wire

@@ design/mtie_ctrl.sv @@
// Sequencing state machine for the MTIE block.
`default_nettype none

module mtie_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire mtie_pkg::t_status i_status,
    output mtie_pkg::t_cmd        o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_SWING,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.in_window) begin
                    n_state = S_FINISH;
                end else if (i_status.scan_empty) begin
                    n_state = S_SWING;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.read = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_SWING;  // last read data folds this cycle
            end
            S_SWING: begin
                o_cmd.swing = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (!i_status.is_last) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ design/mtie_dpath.sv @@
// Ring memory, window min/max scan, worst swing and result register.
`default_nettype none

module mtie_dpath #(
    parameter int WINDOW_MAX = 255,
    parameter int PHASE_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    input  wire logic [mtie_pkg::WLEN_BITS-1:0]      i_cfg_data,
    input  wire logic signed [mtie_pkg::SAMPLE_BITS-1:0] i_phase_sample,
    input  wire logic                                i_last_sample,
    input  wire mtie_pkg::t_cmd                      i_cmd,
    output mtie_pkg::t_status                        o_status,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [mtie_pkg::SWING_BITS-1:0]          o_worst_swing,
    output logic                                     o_result_valid
);

    localparam int DEPTH   = WINDOW_MAX + 1;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int SEEN_W  = $clog2(DEPTH + 1);
    localparam int WL_W    = mtie_pkg::WLEN_BITS;
    localparam int CMP_W   = (SEEN_W > WL_W + 1) ? SEEN_W : WL_W + 1;
    localparam int WMAX_W  = 17;
    localparam int DIFF_W  = PHASE_BITS + 1;
    localparam int SW_W    = mtie_pkg::SWING_BITS;

    logic [PHASE_BITS-1:0] r_ring [DEPTH];

    logic [WL_W-1:0]       r_window_len;
    logic [PTR_W-1:0]      r_wp;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [SEEN_W-1:0]     r_seen;
    logic [SW_W-1:0]       r_largest;
    logic [WL_W-1:0]       r_m;
    logic [WL_W-1:0]       r_cnt;
    logic                  r_last;
    logic                  r_rd_vld;
    logic [PHASE_BITS-1:0] r_rdata;
    logic [PHASE_BITS-1:0] r_hi;
    logic [PHASE_BITS-1:0] r_lo;
    logic                  r_out_vld;
    logic [SW_W-1:0]       r_out_swing;
    logic                  r_out_flag;

    logic [PHASE_BITS-1:0] sample_ext;
    logic [WL_W-1:0]       eff_m;
    logic [DIFF_W-1:0]     diff;
    logic [SW_W-1:0]       swing;

    // truncation to PHASE_BITS; a wider phase zero-extends the field
    if (PHASE_BITS <= mtie_pkg::SAMPLE_BITS) begin : g_ext_narrow
        assign sample_ext = i_phase_sample[PHASE_BITS-1:0];
    end else begin : g_ext_wide
        assign sample_ext = {{(PHASE_BITS - mtie_pkg::SAMPLE_BITS){1'b0}}, i_phase_sample};
    end

    // window clamp to WINDOW_MAX
    assign eff_m = ({{(WMAX_W - WL_W){1'b0}}, r_window_len} > WMAX_W'(WINDOW_MAX))
                 ? WL_W'(WINDOW_MAX) : r_window_len;

    assign diff = {r_hi[PHASE_BITS-1], r_hi} - {r_lo[PHASE_BITS-1], r_lo};

    if (DIFF_W > SW_W) begin : g_sat
        assign swing = (|diff[DIFF_W-1:SW_W]) ? '1 : diff[SW_W-1:0];
    end else begin : g_nosat
        assign swing = SW_W'(diff);
    end

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        ptr_dec = (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ring[r_wp] <= sample_ext;
        end
        if (i_cmd.read) begin
            r_rdata <= r_ring[r_rd_ptr];
        end
    end

    // scan payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hi     <= sample_ext;
            r_lo     <= sample_ext;
            r_rd_ptr <= ptr_dec(r_wp);
            r_cnt    <= eff_m;
            r_last   <= i_last_sample;
        end else begin
            if (i_cmd.read) begin
                r_rd_ptr <= ptr_dec(r_rd_ptr);
                r_cnt    <= r_cnt - 1'b1;
            end
            if (r_rd_vld) begin
                if ($signed(r_rdata) > $signed(r_hi)) begin
                    r_hi <= r_rdata;
                end
                if ($signed(r_rdata) < $signed(r_lo)) begin
                    r_lo <= r_rdata;
                end
            end
        end
        if (i_cmd.finish) begin
            r_out_swing <= o_status.in_window ? r_largest : '0;
            r_out_flag  <= o_status.in_window;
        end
    end

    // series control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WL_W'(1);
            r_wp         <= '0;
            r_seen       <= '0;
            r_largest    <= '0;
            r_m          <= WL_W'(1);
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.read;
            if (i_cfg_valid) begin
                r_window_len <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_wp <= ptr_inc(r_wp);
                r_m  <= eff_m;
                if (r_seen != SEEN_W'(DEPTH)) begin
                    r_seen <= r_seen + 1'b1;
                end
            end
            if (i_cmd.swing && (swing > r_largest)) begin
                r_largest <= swing;
            end
            if (i_cmd.finish) begin
                r_wp      <= '0;
                r_seen    <= '0;
                r_largest <= '0;
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_status.in_window  = CMP_W'(r_seen) >= (CMP_W'(r_m) + 1'b1);
    assign o_status.scan_empty = (r_cnt == '0);
    assign o_status.scan_last  = (r_cnt == WL_W'(1));
    assign o_status.is_last    = r_last;
    assign o_status.out_free   = !r_out_vld || !i_stall;

    assign o_valid        = r_out_vld;
    assign o_worst_swing  = r_out_swing;
    assign o_result_valid = r_out_flag;

endmodule

`default_nettype wire

@@ design/max_time_interval_error.sv @@
// MTIE top level: phase samples in, worst window swing out per series.
// Each item is accepted, checked for window fill, then m ring entries (m = clamped window_len)
// are scanned one read at a time and the window swing is folded; with no complete window yet
// the scan and fold are skipped. One item at a time: the next is taken only once this one is
// through; a last item also waits while an earlier result is held.
// Sync reset clears series state, window_len=1, ring kept.
`default_nettype none

module max_time_interval_error #(
    parameter int WINDOW_MAX = 255,  // widest window m; ring holds WINDOW_MAX+1 samples
    parameter int PHASE_BITS = 32    // bits of each stored phase reading
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // configuration: window_len
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [mtie_pkg::WLEN_BITS-1:0]          i_cfg_data,
    // sample items
    input  wire logic                                    i_valid,
    output logic                                         o_stall,
    input  wire logic signed [mtie_pkg::SAMPLE_BITS-1:0] i_phase_sample,
    input  wire logic                                    i_last_sample,
    // result items
    output logic                                         o_valid,
    input  wire logic                                    i_stall,
    output logic [mtie_pkg::SWING_BITS-1:0]              o_worst_swing,
    output logic                                         o_result_valid
);

    mtie_pkg::t_cmd    cmd;
    mtie_pkg::t_status status;

    // Register writes are to land only while idle (the block does not enforce this); the port never pushes back.
    assign o_cfg_ready = 1'b1;

    // Controller: accept, check window fill, scan m ring entries, fold swing,
    // then emit on the last item of a series.
    mtie_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath: ring memory, running max/min, worst swing, result register.
    mtie_dpath #(
        .WINDOW_MAX (WINDOW_MAX),
        .PHASE_BITS (PHASE_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid & o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_phase_sample (i_phase_sample),
        .i_last_sample  (i_last_sample),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_worst_swing  (o_worst_swing),
        .o_result_valid (o_result_valid)
    );

endmodule

`default_nettype wire

@@ design/mtie_checker.sv @@
// Port-level assertion checker for the MTIE block, bound to the top level.
`default_nettype none

`include "max_time_interval_error_macros.svh"

module mtie_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_valid,
    input wire logic                               o_stall,
    input wire logic                               o_valid,
    input wire logic                               i_stall,
    input wire logic [mtie_pkg::SWING_BITS-1:0]    o_worst_swing,
    input wire logic                               o_result_valid
);

    // an item in work blocks the next one
    `MTIE_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "accept did not stall")

    // a short series reports zero swing
    `MTIE_ASSERT_SAME(a_short_zero, o_valid && !o_result_valid, o_worst_swing == '0, "nonzero swing")

    // a held result stays offered
    `MTIE_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid, "result dropped while stalled")

    // a held result keeps its swing
    `MTIE_ASSERT_NEXT(a_out_stable, o_valid && i_stall, $stable(o_worst_swing), "swing changed")

endmodule

bind max_time_interval_error mtie_checker u_mtie_checker (.*);

`default_nettype wire
